### hw/rtl/jsu_pkg.sv
// ============================================================================
// jsu_pkg: shared types and constants for the JSON string unescaper
// Holds the payload structs, the status codes and the character constants
// used by the decoder.
// ============================================================================
`default_nettype none

package jsu_pkg;

  // Input payload: one raw byte of JSON text.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  // Result payload: an optional decoded byte and an optional status.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_QUOTE  = 2'd1;
  localparam logic [1:0] ST_BAD_HEX   = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  // Characters with a special meaning in the string syntax.
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_QMARK     = 8'h3F;

  // Control codes produced by the single-letter escapes.
  localparam logic [7:0] CC_LF = 8'h0A;
  localparam logic [7:0] CC_CR = 8'h0D;
  localparam logic [7:0] CC_HT = 8'h09;
  localparam logic [7:0] CC_BS = 8'h08;
  localparam logic [7:0] CC_FF = 8'h0C;

  // Number of hex digits in a unicode escape, minus one.
  localparam logic [1:0] HEX_LAST_DIGIT = 2'd3;

endpackage : jsu_pkg

`default_nettype wire

### hw/rtl/json_string_unescape.sv
// ============================================================================
// json_string_unescape: streaming JSON string value decoder
// Consumes one byte of JSON text per transaction, starting at the opening
// quote, and produces decoded characters and a final status.
// ============================================================================
//
//   Channel  Direction  Handshake            Payload
//   -------  ---------  -------------------  -------------------------------
//   in_      input      in_valid/in_ready    in_data  (jsu_pkg::in_item_t)
//   out_     output     out_valid/out_ready  out_data (jsu_pkg::out_item_t)
//
// One input transaction is taken per cycle. The parser state is updated at
// the clock edge that accepts the byte, and any result is written into the
// output register at that same edge. Bytes that produce no result (opening
// quote, backslash, 'u' and the first three hex digits) only update the state.
// The only thing that stalls input is a result held in the output register
// that the consumer has not yet taken. Reset (rst_n low, synchronous) returns
// the parser to idle and empties the output register.
`default_nettype none

module json_string_unescape (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire jsu_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output jsu_pkg::out_item_t      out_data
);

  import jsu_pkg::*;

  // Parser modes: waiting for the opening quote, inside the string body,
  // right after a backslash, and collecting the digits of a unicode escape.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_BODY = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [1:0] hex_cnt_r, hex_cnt_nxt;
  // Only three digits are ever held: the fourth is combined on the fly.
  logic [11:0] acc_r, acc_nxt;

  logic       out_valid_r;
  out_item_t  out_data_r;

  logic       in_fire;
  logic       has_res;
  out_item_t  res;

  logic [7:0] ch;
  logic       last;
  logic       hex_ok;
  logic [3:0] hex_dv;
  logic [7:0] esc_char;
  logic [7:0] uni_char;

  assign ch   = in_data.in_byte;
  assign last = in_data.end_of_input;

  // The output register can take a new result when it is empty or being
  // drained in this same cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Hex digit decode.
  always_comb begin
    hex_ok = 1'b1;
    hex_dv = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      hex_dv = 4'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      hex_dv = 4'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      hex_dv = 4'(ch - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Single-letter escapes; any other byte stands for itself.
  always_comb begin
    case (ch)
      CH_LOWER_N: esc_char = CC_LF;
      CH_LOWER_R: esc_char = CC_CR;
      CH_LOWER_T: esc_char = CC_HT;
      CH_LOWER_B: esc_char = CC_BS;
      CH_LOWER_F: esc_char = CC_FF;
      default:    esc_char = ch;
    endcase
  end

  // The full code is {acc_r, hex_dv}; it fits in seven bits exactly when
  // the top nine bits are zero. Larger codes are replaced by a question mark.
  assign uni_char = (acc_r[11:3] == 9'd0) ? {acc_r[3:0], hex_dv} : CH_QMARK;

  // Next-state and result logic for the accepted byte.
  always_comb begin
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    acc_nxt     = acc_r;
    has_res     = 1'b0;
    res         = '0;

    case (mode_r)
      MODE_IDLE: begin
        if (ch != CH_QUOTE) begin
          has_res      = 1'b1;
          res.done_res = 1'b1;
          res.status   = ST_NO_QUOTE;
        end else if (last) begin
          has_res      = 1'b1;
          res.done_res = 1'b1;
          res.status   = ST_TRUNCATED;
        end else begin
          mode_nxt = MODE_BODY;
        end
      end

      MODE_BODY: begin
        if (ch == CH_QUOTE) begin
          has_res      = 1'b1;
          res.done_res = 1'b1;
          res.status   = ST_OK;
        end else if (ch == CH_BACKSLASH) begin
          if (last) begin
            has_res      = 1'b1;
            res.done_res = 1'b1;
            res.status   = ST_TRUNCATED;
          end else begin
            mode_nxt = MODE_ESC;
          end
        end else begin
          has_res        = 1'b1;
          res.byte_valid = 1'b1;
          res.out_byte   = ch;
          res.done_res   = last;
          res.status     = last ? ST_TRUNCATED : ST_OK;
        end
      end

      MODE_ESC: begin
        if (ch == CH_LOWER_U) begin
          if (last) begin
            has_res      = 1'b1;
            res.done_res = 1'b1;
            res.status   = ST_TRUNCATED;
          end else begin
            mode_nxt    = MODE_HEX;
            hex_cnt_nxt = 2'd0;
            acc_nxt     = '0;
          end
        end else begin
          mode_nxt       = MODE_BODY;
          has_res        = 1'b1;
          res.byte_valid = 1'b1;
          res.out_byte   = esc_char;
          res.done_res   = last;
          res.status     = last ? ST_TRUNCATED : ST_OK;
        end
      end

      MODE_HEX: begin
        // Truncation is checked before the digit itself.
        if (last && (hex_cnt_r != HEX_LAST_DIGIT)) begin
          has_res      = 1'b1;
          res.done_res = 1'b1;
          res.status   = ST_TRUNCATED;
        end else if (!hex_ok) begin
          has_res      = 1'b1;
          res.done_res = 1'b1;
          res.status   = ST_BAD_HEX;
        end else if (hex_cnt_r != HEX_LAST_DIGIT) begin
          acc_nxt     = {acc_r[7:0], hex_dv};
          hex_cnt_nxt = hex_cnt_r + 2'd1;
        end else begin
          mode_nxt       = MODE_BODY;
          hex_cnt_nxt    = 2'd0;
          acc_nxt        = '0;
          has_res        = 1'b1;
          res.byte_valid = 1'b1;
          res.out_byte   = uni_char;
          res.done_res   = last;
          res.status     = last ? ST_TRUNCATED : ST_OK;
        end
      end

      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase

    // Any status ends the string and sends the parser back to idle.
    if (has_res && res.done_res) begin
      mode_nxt    = MODE_IDLE;
      hex_cnt_nxt = 2'd0;
      acc_nxt     = '0;
    end
  end

  // Parser state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      hex_cnt_r   <= 2'd0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_r    <= mode_nxt;
        hex_cnt_r <= hex_cnt_nxt;
        acc_r     <= acc_nxt;
      end
      if (in_ready) begin
        out_valid_r <= in_fire && has_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && has_res) begin
      out_data_r <= res;
    end
  end

  // A counted hex digit only exists while a unicode escape is open.
  a_cnt_only_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
    (hex_cnt_r != 2'd0) |-> (mode_r == MODE_HEX))
    else $error("hex digit count set outside a unicode escape");

  // A transaction that ends the string leaves the parser idle.
  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && has_res && res.done_res) |=> (mode_r == MODE_IDLE))
    else $error("parser not idle after a final status");

  // Without an end of string the status field stays zero.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.done_res) |-> (out_data_r.status == ST_OK))
    else $error("status set on a result that does not end the string");

  // Without a character the byte field stays zero.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.byte_valid) |-> (out_data_r.out_byte == 8'd0))
    else $error("byte set on a result without a character");

  // Every result carries a character, a status, or both.
  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.byte_valid || out_data_r.done_res))
    else $error("empty result in the output register");

endmodule : json_string_unescape

`default_nettype wire

### tb/tb_json_string_unescape.sv
// ============================================================================
// tb_json_string_unescape: self-checking bench for the JSON string decoder
// Feeds byte streams of JSON string values, directed and random, through the
// valid/ready input channel. A behavioral decoder in the bench predicts each
// result, and every result transaction is checked field by field against it.
// ============================================================================

module tb_json_string_unescape;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  // The run is ended as failed if it has not finished after this many cycles.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Number of input transactions the stimulus aims for.
  localparam int TARGET_BYTES = 900;

  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Decoder position within a string value.
  typedef enum logic [1:0] {
    PM_IDLE,
    PM_BODY,
    PM_ESC,
    PM_HEX
  } parse_mode_e;

  // One pending input byte; drain_first makes the sender wait until every
  // expected result has arrived before it offers this byte.
  typedef struct packed {
    logic     drain_first;
    in_item_t data;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  stim_t       stim_q[$];
  stim_t       next_stim;
  out_item_t   expected_out_q[$];
  logic [7:0]  text_buf[$];
  bit          drain_next = 1'b0;
  bit          in_taken = 1'b0;
  int          err_count = 0;
  int unsigned cycle_count = 0;

  // Sender burst shaping.
  int burst_left = 8;
  int gap_left = 0;

  // Receiver stall shaping, counted in the receiver's own cycles.
  int rx_cycle = 0;
  int hold_left = 0;

  // Predicted decoder state.
  parse_mode_e pmode = PM_IDLE;
  logic [1:0]  hex_cnt = 2'd0;
  logic [15:0] code_acc = 16'd0;

  json_string_unescape dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral decoder
  // --------------------------------------------------------------------------

  // Bit 4 set means the byte is a hex digit; bits 3:0 hold its value.
  // Digits '0'..'9' carry their value in the low nibble, and both letter
  // ranges ('A'..'F' and 'a'..'f') start at a low nibble of 1.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  // A decoded character; on the last byte of the buffer it also ends the
  // string as truncated.
  function automatic out_item_t char_out(input logic [7:0] c, input logic last);
    out_item_t r;
    r = '0;
    r.byte_valid = 1'b1;
    r.out_byte   = c;
    r.done_res   = last;
    r.status     = last ? ST_TRUNCATED : ST_OK;
    return r;
  endfunction

  function automatic out_item_t status_only(input logic [1:0] st);
    out_item_t r;
    r = '0;
    r.done_res = 1'b1;
    r.status   = st;
    return r;
  endfunction

  // Advances the predicted state by one accepted byte. produced tells whether
  // the byte causes a result transaction.
  task automatic decode_byte(input in_item_t it, output bit produced,
                             output out_item_t res);
    logic [7:0]  ch;
    logic        last;
    logic [4:0]  digit;
    logic [15:0] acc;
    ch = it.in_byte;
    last = it.end_of_input;
    produced = 1'b1;
    res = '0;
    case (pmode)
      PM_IDLE: begin
        if (ch != CH_QUOTE) res = status_only(ST_NO_QUOTE);
        else if (last) res = status_only(ST_TRUNCATED);
        else begin
          pmode = PM_BODY;
          produced = 1'b0;
        end
      end
      PM_BODY: begin
        if (ch == CH_QUOTE) begin
          // A closing quote is a success even on the last byte.
          res = status_only(ST_OK);
        end else if (ch == CH_BACKSLASH) begin
          if (last) res = status_only(ST_TRUNCATED);
          else begin
            pmode = PM_ESC;
            produced = 1'b0;
          end
        end else res = char_out(ch, last);
      end
      PM_ESC: begin
        if (ch == CH_LOWER_U) begin
          if (last) res = status_only(ST_TRUNCATED);
          else begin
            pmode = PM_HEX;
            hex_cnt = 2'd0;
            code_acc = 16'd0;
            produced = 1'b0;
          end
        end else begin
          pmode = PM_BODY;
          case (ch)
            CH_LOWER_N: res = char_out(CC_LF, last);
            CH_LOWER_R: res = char_out(CC_CR, last);
            CH_LOWER_T: res = char_out(CC_HT, last);
            CH_LOWER_B: res = char_out(CC_BS, last);
            CH_LOWER_F: res = char_out(CC_FF, last);
            default:    res = char_out(ch, last);
          endcase
        end
      end
      default: begin
        digit = hex_digit(ch);
        // Running out of input is checked before the digit itself.
        if (last && hex_cnt != HEX_LAST_DIGIT) res = status_only(ST_TRUNCATED);
        else if (!digit[4]) res = status_only(ST_BAD_HEX);
        else begin
          acc = {code_acc[11:0], digit[3:0]};
          if (hex_cnt != HEX_LAST_DIGIT) begin
            code_acc = acc;
            hex_cnt = hex_cnt + 2'd1;
            produced = 1'b0;
          end else begin
            pmode = PM_BODY;
            hex_cnt = 2'd0;
            code_acc = 16'd0;
            // Codes beyond 7-bit ASCII are replaced by a question mark.
            res = char_out((acc <= 16'h007F) ? acc[7:0] : CH_QMARK, last);
          end
        end
      end
    endcase
    // Any status sends the decoder back to waiting for an opening quote.
    if (produced && res.done_res) begin
      pmode = PM_IDLE;
      hex_cnt = 2'd0;
      code_acc = 16'd0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] b, input logic last);
    stim_t s;
    s.drain_first = drain_next;
    s.data.in_byte = b;
    s.data.end_of_input = last;
    stim_q = {stim_q, s};
    drain_next = 1'b0;
  endtask

  task automatic push_text(input string txt, input logic last_at_end);
    for (int i = 0; i < txt.len(); i++)
      push_byte(txt[i], last_at_end && (i == txt.len() - 1));
  endtask

  // Mostly printable characters, sometimes any byte, never one that has a
  // meaning of its own in the body.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(32, 126));
    end while (b == CH_QUOTE || b == CH_BACKSLASH);
    return b;
  endfunction

  // The byte after a backslash in a single-character escape.
  function automatic logic [7:0] escape_letter();
    logic [7:0] b;
    case ($urandom_range(0, 8))
      0: b = CH_QUOTE;
      1: b = CH_BACKSLASH;
      2: b = CH_SLASH;
      3: b = CH_LOWER_N;
      4: b = CH_LOWER_R;
      5: b = CH_LOWER_T;
      6: b = CH_LOWER_B;
      7: b = CH_LOWER_F;
      default: begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_LOWER_U);
      end
    endcase
    return b;
  endfunction

  // One string value with random content. Most are well formed; some carry
  // a bad hex digit, and some are cut short by an end-of-input flag on a
  // random byte.
  task automatic add_random_string();
    int          n;
    int          kind;
    int          cut;
    logic [15:0] code;
    logic [3:0]  nib;
    logic [7:0]  b;
    bit          broken;
    bit          upper;
    bit          close_last;
    text_buf.delete();
    text_buf = {text_buf, CH_QUOTE};
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    broken = 1'b0;
    for (int i = 0; i < n && !broken; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) text_buf = {text_buf, plain_byte()};
      else if (kind < 80) begin
        text_buf = {text_buf, CH_BACKSLASH};
        text_buf = {text_buf, escape_letter()};
      end else begin
        text_buf = {text_buf, CH_BACKSLASH};
        text_buf = {text_buf, CH_LOWER_U};
        // Half the codes fit in 7-bit ASCII, the rest span the full range.
        if ($urandom_range(0, 1) == 0) code = 16'($urandom_range(0, 127));
        else code = 16'($urandom_range(0, 65535));
        upper = 1'($urandom_range(0, 1));
        for (int d = 3; d >= 0 && !broken; d--) begin
          if ($urandom_range(0, 39) == 0) begin
            do b = 8'($urandom_range(0, 255)); while (hex_digit(b) > 5'h0F);
            text_buf = {text_buf, b};
            broken = 1'b1;
          end else begin
            nib = code[4*d +: 4];
            b = (nib < 4'd10) ? {4'h3, nib} : {(upper ? 4'h4 : 4'h6), nib - 4'd9};
            text_buf = {text_buf, b};
          end
        end
      end
    end
    // A bad hex digit ends the string, so nothing follows it.
    if (!broken) text_buf = {text_buf, CH_QUOTE};
    close_last = 1'($urandom_range(0, 1));
    cut = text_buf.size() - 1;
    if ($urandom_range(0, 9) == 0) cut = $urandom_range(0, text_buf.size() - 1);
    for (int i = 0; i <= cut; i++)
      push_byte(text_buf[i], (i == cut) && (cut < text_buf.size() - 1 || close_last));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------

  initial begin : stimulus
    int strings;
    int noise;
    logic [7:0] b;

    // Directed bytes first. Without an opening quote, both extremes.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    // An opening quote that is the last byte of the buffer.
    push_byte(CH_QUOTE, 1'b1);
    // Extreme body bytes, a control escape, the largest ASCII code and a code
    // beyond ASCII in unicode escapes, and a proper close.
    push_byte(CH_QUOTE, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_text("\\n\\u007F\\uFFFF\"", 1'b0);
    // A backslash that is the last byte.
    push_text("\"\\", 1'b1);
    // A character that is not a hex digit inside a unicode escape.
    push_text("\"\\u0G", 1'b0);

    // Random strings, with an occasional run of stray bytes between them and
    // a regular pause of the sender until the decoder has drained.
    strings = 0;
    while (stim_q.size() < TARGET_BYTES) begin
      if ($urandom_range(0, 14) == 0) begin
        noise = $urandom_range(1, 3);
        repeat (noise) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
          push_byte(b, 1'($urandom_range(0, 1)));
        end
      end
      drain_next = (strings % 25 == 24);
      add_random_string();
      strings++;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until every byte is taken and every predicted result has come,
    // then let the clock run on so the output register can show anything extra.
    // The check runs at the rising edge, where the driven inputs are stable.
    while (stim_q.size() != 0 || in_valid || expected_out_q.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: presents bytes at the falling edge, in bursts separated by gaps.
  // A byte stays on the bus until the monitor has seen it accepted.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (stim_q.size() == 0 ||
                   (stim_q[0].drain_first && expected_out_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        next_stim = stim_q.pop_front();
        in_data <= next_stim.data;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          // Now and then a long burst with no idling at all.
          burst_left <= ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: cycles through stall patterns, and twice holds off for a long
  // stretch so that the output register fills and the input backs up.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_cycle == 600 || rx_cycle == 2500) begin
      hold_left <= 300;
      out_ready <= 1'b0;
    end else begin
      case (rx_cycle[8:7])
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= 1'($urandom_range(0, 1));
        2'd2:    out_ready <= ($urandom_range(0, 5) == 0);
        default: out_ready <= (rx_cycle[1:0] != 2'd3);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at the rising edge, checks each result transaction against the
  // oldest prediction and predicts the outcome of each accepted byte.
  // --------------------------------------------------------------------------
  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname,
               want, got);
      err_count = err_count + 1;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t pred;
    bit        produced;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_out_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time,
                   out_data);
          err_count = err_count + 1;
        end else begin
          want = expected_out_q.pop_front();
          check_field("byte_valid", want.byte_valid, out_data.byte_valid);
          check_field("out_byte", want.out_byte, out_data.out_byte);
          check_field("done_res", want.done_res, out_data.done_res);
          check_field("status", want.status, out_data.status);
        end
      end
      if (in_valid && in_ready) begin
        decode_byte(in_data, produced, pred);
        if (produced) expected_out_q = {expected_out_q, pred};
      end
    end
    in_taken <= rst_n && in_valid && in_ready;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still expected", $time,
               expected_out_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

### filelist.f
hw/rtl/jsu_pkg.sv
hw/rtl/json_string_unescape.sv
tb/tb_json_string_unescape.sv
